[src/xnv_pkg.sv]
// ----------------------------------------------------------------------------
// xnv_pkg: shared types and constants of the XML name validator
// Holds the item types of both channels, the lead byte classes and the
// XML name character test on decoded code points.
// ----------------------------------------------------------------------------
package xnv_pkg;

  typedef struct packed {
    logic [7:0] name_byte;
    logic       has_byte;
    logic       is_attribute;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic verdict;
  } out_item_t;

  // Held item from the input stage to the checker
  typedef struct packed {
    logic     valid;
    in_item_t item;
  } stage_t;

  typedef enum logic [2:0] {
    LEAD_ASCII,
    LEAD_TWO,
    LEAD_THREE,
    LEAD_FOUR,
    LEAD_BAD
  } lead_kind_t;

  localparam logic       VERDICT_OK      = 1'b0;
  localparam logic       VERDICT_ILLEGAL = 1'b1;
  localparam logic [1:0] PREFIX_LEN      = 2'd3;

  function automatic lead_kind_t lead_kind(input logic [7:0] b);
    lead_kind_t k;
    if (b < 8'h80) begin
      k = LEAD_ASCII;
    end else if (b inside {[8'hC0:8'hDF]}) begin
      k = LEAD_TWO;
    end else if (b inside {[8'hE0:8'hEF]}) begin
      k = LEAD_THREE;
    end else if (b inside {[8'hF0:8'hF7]}) begin
      k = LEAD_FOUR;
    end else begin
      k = LEAD_BAD;
    end
    return k;
  endfunction

  // Expected lowercase byte of the "xml" prefix at a position
  function automatic logic [7:0] prefix_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = 8'h78;
      2'd1:    c = 8'h6D;
      2'd2:    c = 8'h6C;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic ascii_digit(input logic [7:0] b);
    return b inside {[8'h30:8'h39]};
  endfunction

  function automatic logic [7:0] fold_case(input logic [7:0] b);
    return (b inside {[8'h41:8'h5A]}) ? (b | 8'h20) : b;
  endfunction

  function automatic logic name_char(input logic [20:0] c);
    return c inside {21'h5F, 21'h3A, 21'h2D, 21'h2E, 21'hB7,
                     [21'h30:21'h39], [21'h41:21'h5A], [21'h61:21'h7A],
                     [21'hC0:21'hD6], [21'hD8:21'hF6], [21'hF8:21'h2FF],
                     [21'h300:21'h36F], [21'h370:21'h37D], [21'h37F:21'h1FFF],
                     [21'h200C:21'h200D], [21'h203F:21'h2040],
                     [21'h2070:21'h218F], [21'h2C00:21'h2FEF],
                     [21'h3001:21'hD7FF], [21'hF900:21'hFDCF],
                     [21'hFDF0:21'hFFFD], [21'h10000:21'hEFFFF]};
  endfunction

endpackage

[src/xnv_stream_if.sv]
// ----------------------------------------------------------------------------
// xnv_stream_if: valid/ready channel
// Carries one payload per transaction; source drives valid and payload.
// ----------------------------------------------------------------------------
interface xnv_stream_if #(
  parameter type payload_t = logic [7:0]
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[src/xnv_in_stage.sv]
// ----------------------------------------------------------------------------
// xnv_in_stage: input register
// Holds one byte transaction; refills in the cycle the held item moves on.
// ----------------------------------------------------------------------------
module xnv_in_stage (
  input  logic            clk,
  input  logic            rst,
  xnv_stream_if.sink      bytes,
  input  logic            take,
  output xnv_pkg::stage_t held
);

  logic              valid;
  xnv_pkg::in_item_t item;
  logic              accept;

  assign bytes.ready = !valid || take;
  assign accept      = bytes.valid && bytes.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (accept) begin
      valid <= 1'b1;
    end else if (take) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= bytes.payload;
    end
  end

  assign held.valid = valid;
  assign held.item  = item;

endmodule

[src/xnv_name_check.sv]
// ----------------------------------------------------------------------------
// xnv_name_check: UTF-8 decode, name rules and verdict register
// Updates the per-name state on each held item and registers the verdict.
// ----------------------------------------------------------------------------
module xnv_name_check (
  input  logic            clk,
  input  logic            rst,
  input  xnv_pkg::stage_t held,
  output logic            take,
  xnv_stream_if.source    result
);

  localparam logic [1:0] PREFIX_LEN_L = xnv_pkg::PREFIX_LEN;

  logic [1:0]  pend, pend_next;
  logic [20:0] acc, acc_next;
  logic [1:0]  seen, seen_next;
  logic        pfx, pfx_next;
  logic        failed, failed_next;
  logic        attr, attr_next;
  logic        out_valid;
  logic        verdict, verdict_next;
  logic        closing;
  logic [7:0]  b;

  assign b       = held.item.name_byte;
  assign take    = held.valid && (!held.item.last || !out_valid || result.ready);
  assign closing = take && held.item.last;

  always_comb begin
    pend_next   = pend;
    acc_next    = acc;
    seen_next   = seen;
    pfx_next    = pfx;
    failed_next = failed;
    attr_next   = (seen == 2'd0) ? held.item.is_attribute : attr;

    if (held.item.has_byte) begin
      if (seen != PREFIX_LEN_L && xnv_pkg::fold_case(b) != xnv_pkg::prefix_char(seen)) begin
        pfx_next = 1'b0;
      end
      if (seen == 2'd0 && xnv_pkg::ascii_digit(b)) begin
        failed_next = 1'b1;
      end

      if (pend != 2'd0) begin
        acc_next  = {acc[14:0], b[5:0]};
        pend_next = pend - 2'd1;
        if (pend == 2'd1 && !xnv_pkg::name_char(acc_next)) begin
          failed_next = 1'b1;
        end
      end else begin
        case (xnv_pkg::lead_kind(b))
          xnv_pkg::LEAD_ASCII: begin
            acc_next = {13'd0, b};
            if (!xnv_pkg::name_char(acc_next)) begin
              failed_next = 1'b1;
            end
          end
          xnv_pkg::LEAD_TWO: begin
            acc_next  = {16'd0, b[4:0]};
            pend_next = 2'd1;
          end
          xnv_pkg::LEAD_THREE: begin
            acc_next  = {17'd0, b[3:0]};
            pend_next = 2'd2;
          end
          xnv_pkg::LEAD_FOUR: begin
            acc_next  = {18'd0, b[2:0]};
            pend_next = 2'd3;
          end
          default: begin
            acc_next    = 21'd0;
            failed_next = 1'b1;
          end
        endcase
      end

      if (seen != 2'd3) begin
        seen_next = seen + 2'd1;
      end
    end

    // Verdict from the state after this byte
    if (failed_next || seen_next == 2'd0 || pend_next != 2'd0 ||
        (!attr_next && pfx_next && seen_next == PREFIX_LEN_L)) begin
      verdict_next = xnv_pkg::VERDICT_ILLEGAL;
    end else begin
      verdict_next = xnv_pkg::VERDICT_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || closing) begin
      pend   <= 2'd0;
      acc    <= 21'd0;
      seen   <= 2'd0;
      pfx    <= 1'b1;
      failed <= 1'b0;
      attr   <= 1'b0;
    end else if (take) begin
      pend   <= pend_next;
      acc    <= acc_next;
      seen   <= seen_next;
      pfx    <= pfx_next;
      failed <= failed_next;
      attr   <= attr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (closing) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (closing) begin
      verdict <= verdict_next;
    end
  end

  assign result.valid           = out_valid;
  assign result.payload.verdict = verdict;

  // A closing item must never overwrite an untaken verdict
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    closing |-> (!out_valid || result.ready))
    else $error("verdict overwritten before it was taken");

  // Closing a name returns the per-name state to its reset value
  a_state_cleared: assert property (@(posedge clk) disable iff (rst)
    closing |=> (seen == 2'd0 && pend == 2'd0 && pfx && !failed))
    else $error("name state not cleared after last item");

  // Continuations are only awaited once a byte has been taken
  a_pend_needs_byte: assert property (@(posedge clk) disable iff (rst)
    (seen == 2'd0) |-> (pend == 2'd0))
    else $error("pending continuations with no byte taken");

  // An error sticks until the name closes
  a_failed_sticky: assert property (@(posedge clk) disable iff (rst)
    (failed && !closing) |=> failed)
    else $error("error flag dropped inside a name");

endmodule

[src/xml_name_utf8_validator_top.sv]
// ----------------------------------------------------------------------------
// xml_name_utf8_validator_top: XML name validator over UTF-8 bytes
// Checks one tag or attribute name, at most one byte per transaction, and gives
// one verdict transaction when the name closes.
// ----------------------------------------------------------------------------
//
//   channel  role    payload                                     per name
//   -------  ------  ------------------------------------------  ----------------
//   bytes    sink    name_byte, has_byte, is_attribute, last      one or more
//   result   source  verdict (0 ok, 1 illegal)                    one, after last
//
// Flow: one byte transaction per clock, unless a held result stalls a
// closing item. A byte sits in the input register, where the decode and
// name rules settle; the verdict register loads as the closing item moves
// on and holds the verdict until it is taken.
// Reset: rst is synchronous; it empties both registers and restores the
// per-name state (no byte seen, prefix still matching, no error).
// Stalls: a held result stalls only a closing item in the input register,
// and the bytes behind it wait; bytes before it keep flowing. The input
// register refills in the cycle its item moves on.
//
module xml_name_utf8_validator_top (
  input  logic         clk,
  input  logic         rst,
  xnv_stream_if.sink   bytes,
  xnv_stream_if.source result
);

  // Held byte and its advance strobe
  xnv_pkg::stage_t held;
  logic            take;

  // Register the incoming byte transaction
  xnv_in_stage u_in_stage (
    .clk   (clk),
    .rst   (rst),
    .bytes (bytes),
    .take  (take),
    .held  (held)
  );

  // Decode, apply the name rules and hold the verdict until taken
  xnv_name_check u_name_check (
    .clk    (clk),
    .rst    (rst),
    .held   (held),
    .take   (take),
    .result (result)
  );

endmodule

[test/tb_xml_name_utf8_validator_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_xml_name_utf8_validator_top: testbench of the XML name validator
// Feeds names to the validator one byte per transaction, first a few
// hand-picked names, then random names that are mostly well-formed UTF-8
// with noise, cut sequences and empty names mixed in. A predictor in this
// file computes the verdict of every closed name, and each verdict
// transaction is checked against the oldest pending one.
// ----------------------------------------------------------------------------
module tb_xml_name_utf8_validator_top;

  localparam int CLK_PERIOD   = 8;
  localparam int RESET_CYCLES = 8;
  localparam int IDLE_PCT     = 14;
  localparam int RANDOM_ITEMS = 1450;
  // Slack after the last pending verdict has been checked.
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 200000;

  logic clk;
  logic rst;

  xnv_stream_if #(.payload_t(xnv_pkg::in_item_t))  bytes_ch ();
  xnv_stream_if #(.payload_t(xnv_pkg::out_item_t)) result_ch ();

  xml_name_utf8_validator_top uut (
    .clk    (clk),
    .rst    (rst),
    .bytes  (bytes_ch.sink),
    .result (result_ch.source)
  );

  // Verdicts still owed by the block, oldest first
  xnv_pkg::out_item_t pending_verdicts[$];

  int  error_count;
  int  items_sent;
  int  cycle_count;
  // When low, both sides run without random gaps
  bit  gaps_on;

  // Predictor state for the name in progress
  logic [1:0]  cont_left;
  logic [20:0] cp_acc;
  logic [1:0]  bytes_taken;
  logic        prefix_hit;
  logic        name_bad;
  logic        attr_mode;

  // Bytes of the next random name
  logic [7:0]  name_bytes[$];

  // --------------------------------------------------------------------------
  // Clock, reset, timeout
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Bail out if the run hangs on a handshake that never completes.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic logic in_span(input logic [20:0] c, input logic [20:0] lo,
                                   input logic [20:0] hi);
    return (c >= lo) && (c <= hi);
  endfunction

  // XML NameChar set over decoded code points
  function automatic logic is_name_cp(input logic [20:0] c);
    return (c == 21'h5F) || (c == 21'h3A) || (c == 21'h2D) || (c == 21'h2E) ||
           (c == 21'hB7) ||
           in_span(c, 21'h30, 21'h39)       || in_span(c, 21'h41, 21'h5A) ||
           in_span(c, 21'h61, 21'h7A)       || in_span(c, 21'hC0, 21'hD6) ||
           in_span(c, 21'hD8, 21'hF6)       || in_span(c, 21'hF8, 21'h2FF) ||
           in_span(c, 21'h300, 21'h36F)     || in_span(c, 21'h370, 21'h37D) ||
           in_span(c, 21'h37F, 21'h1FFF)    || in_span(c, 21'h200C, 21'h200D) ||
           in_span(c, 21'h203F, 21'h2040)   || in_span(c, 21'h2070, 21'h218F) ||
           in_span(c, 21'h2C00, 21'h2FEF)   || in_span(c, 21'h3001, 21'hD7FF) ||
           in_span(c, 21'hF900, 21'hFDCF)   || in_span(c, 21'hFDF0, 21'hFFFD) ||
           in_span(c, 21'h10000, 21'hEFFFF);
  endfunction

  function automatic xnv_pkg::lead_kind_t classify_byte(input logic [7:0] b);
    if (b < 8'h80)                       return xnv_pkg::LEAD_ASCII;
    else if (b >= 8'hC0 && b <= 8'hDF)   return xnv_pkg::LEAD_TWO;
    else if (b >= 8'hE0 && b <= 8'hEF)   return xnv_pkg::LEAD_THREE;
    else if (b >= 8'hF0 && b <= 8'hF7)   return xnv_pkg::LEAD_FOUR;
    else                                 return xnv_pkg::LEAD_BAD;
  endfunction

  task automatic clear_name_state();
    cont_left   = '0;
    cp_acc      = '0;
    bytes_taken = '0;
    prefix_hit  = 1'b1;
    name_bad    = 1'b0;
    attr_mode   = 1'b0;
  endtask

  // Advance the predictor by one accepted transaction; queue a verdict on close.
  task automatic predict_verdict(input xnv_pkg::in_item_t it);
    logic [7:0] b;
    logic [7:0] folded;
    logic [7:0] want;
    logic       illegal;
    b = it.name_byte;
    // Mode is taken on every transaction until the first byte lands.
    if (bytes_taken == 2'd0) attr_mode = it.is_attribute;
    if (it.has_byte) begin
      folded = (b >= 8'h41 && b <= 8'h5A) ? (b | 8'h20) : b;
      case (bytes_taken)
        2'd0:    want = 8'h78;
        2'd1:    want = 8'h6D;
        default: want = 8'h6C;
      endcase
      if (bytes_taken < xnv_pkg::PREFIX_LEN && folded != want) prefix_hit = 1'b0;
      if (bytes_taken == 2'd0 && b >= 8'h30 && b <= 8'h39) name_bad = 1'b1;

      if (cont_left != 2'd0) begin
        // Continuation: take the low six bits, top bits unchecked
        cp_acc    = {cp_acc[14:0], b[5:0]};
        cont_left = cont_left - 2'd1;
        if (cont_left == 2'd0 && !is_name_cp(cp_acc)) name_bad = 1'b1;
      end else begin
        case (classify_byte(b))
          xnv_pkg::LEAD_ASCII: begin
            cp_acc = {13'd0, b};
            if (!is_name_cp(cp_acc)) name_bad = 1'b1;
          end
          xnv_pkg::LEAD_TWO: begin
            cp_acc    = {16'd0, b[4:0]};
            cont_left = 2'd1;
          end
          xnv_pkg::LEAD_THREE: begin
            cp_acc    = {17'd0, b[3:0]};
            cont_left = 2'd2;
          end
          xnv_pkg::LEAD_FOUR: begin
            cp_acc    = {18'd0, b[2:0]};
            cont_left = 2'd3;
          end
          default: begin
            cp_acc   = '0;
            name_bad = 1'b1;
          end
        endcase
      end
      if (bytes_taken < 2'd3) bytes_taken = bytes_taken + 2'd1;
    end

    if (it.last) begin
      illegal = name_bad || (bytes_taken == 2'd0) || (cont_left != 2'd0) ||
                (!attr_mode && prefix_hit && bytes_taken == xnv_pkg::PREFIX_LEN);
      pending_verdicts.push_back(xnv_pkg::out_item_t'{
        verdict: illegal ? xnv_pkg::VERDICT_ILLEGAL : xnv_pkg::VERDICT_OK});
      clear_name_state();
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side: random back-pressure and the checker
  // --------------------------------------------------------------------------
  initial begin
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      result_ch.ready <= !gaps_on || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Compare every verdict transaction with the oldest pending prediction.
  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected verdict %0b with none pending",
                 $time, result_ch.payload.verdict);
        error_count = error_count + 1;
      end else begin
        if (result_ch.payload.verdict !== pending_verdicts[0].verdict) begin
          $display("%0t: verdict mismatch: expected %0b actual %0b",
                   $time, pending_verdicts[0].verdict, result_ch.payload.verdict);
          error_count = error_count + 1;
        end
        void'(pending_verdicts.pop_front());
      end
    end
  end

  // --------------------------------------------------------------------------
  // Byte side
  // --------------------------------------------------------------------------
  // Send one transaction. Entered right after a rising edge; returns at the
  // edge where the block accepted it, with valid still high.
  task automatic send_byte_item(input logic [7:0] b, input logic has,
                                input logic attr, input logic is_last);
    xnv_pkg::in_item_t it;
    it = '{name_byte: b, has_byte: has, is_attribute: attr, last: is_last};
    while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
      bytes_ch.valid <= 1'b0;
      @(posedge clk);
    end
    bytes_ch.valid   <= 1'b1;
    bytes_ch.payload <= it;
    @(posedge clk);
    while (!bytes_ch.ready) @(posedge clk);
    predict_verdict(it);
    if (has || is_last) items_sent = items_sent + 1;
  endtask

  // Hold off the byte side until every pending verdict has been checked.
  task automatic wait_drained();
    bytes_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  // Send the queued name bytes, last flag on the final byte, optionally
  // with byte-less transactions sprinkled in between.
  task automatic send_name_bytes(input logic attr, input bit noisy);
    for (int i = 0; i < name_bytes.size(); i++) begin
      if (noisy && $urandom_range(14) == 0)
        send_byte_item(8'($urandom), 1'b0, 1'($urandom), 1'b0);
      send_byte_item(name_bytes[i], 1'b1, (i == 0) ? attr : 1'($urandom),
                     (i == name_bytes.size() - 1));
    end
  endtask

  // --------------------------------------------------------------------------
  // Directed tests
  // --------------------------------------------------------------------------
  // Empty name, and mode sampling across byte-less transactions
  task automatic test_empty_and_mode();
    send_byte_item(8'hFF, 1'b0, 1'b1, 1'b0);
    send_byte_item(8'h00, 1'b0, 1'b0, 1'b1);
    // Attribute flag on a byte-less lead-in is overruled by the first byte
    send_byte_item(8'h00, 1'b0, 1'b1, 1'b0);
    send_byte_item("x", 1'b1, 1'b0, 1'b0);
    send_byte_item("M", 1'b1, 1'b1, 1'b0);
    send_byte_item("l", 1'b1, 1'b1, 1'b1);
    // Same prefix on an attribute name is fine
    send_byte_item("X", 1'b1, 1'b1, 1'b0);
    send_byte_item("m", 1'b1, 1'b0, 1'b0);
    send_byte_item("L", 1'b1, 1'b0, 1'b1);
  endtask

  // Leading digit, zero byte, stray continuation, invalid lead after a good byte
  task automatic test_bad_bytes();
    send_byte_item("7", 1'b1, 1'b0, 1'b1);
    send_byte_item(8'h00, 1'b1, 1'b1, 1'b1);
    send_byte_item(8'h80, 1'b1, 1'b0, 1'b1);
    send_byte_item("a", 1'b1, 1'b0, 1'b0);
    send_byte_item(8'hFF, 1'b1, 1'b0, 1'b1);
  endtask

  // Two, three and four byte sequences, a cut-short one, unchecked top bits
  task automatic test_multibyte();
    send_byte_item(8'hC2, 1'b1, 1'b0, 1'b0);   // U+00B7
    send_byte_item(8'hB7, 1'b1, 1'b0, 1'b1);
    send_byte_item(8'hE3, 1'b1, 1'b0, 1'b0);   // U+3001
    send_byte_item(8'h80, 1'b1, 1'b0, 1'b0);
    send_byte_item(8'h81, 1'b1, 1'b0, 1'b1);
    send_byte_item(8'hF3, 1'b1, 1'b1, 1'b0);   // U+EFFFF, top of the range
    send_byte_item(8'hAF, 1'b1, 1'b1, 1'b0);
    send_byte_item(8'hBF, 1'b1, 1'b1, 1'b0);
    send_byte_item(8'hBF, 1'b1, 1'b1, 1'b1);
    send_byte_item(8'hC3, 1'b1, 1'b0, 1'b1);   // name ends mid-sequence
    send_byte_item(8'hC3, 1'b1, 1'b0, 1'b0);   // continuation with top bits 00
    send_byte_item(8'h29, 1'b1, 1'b0, 1'b1);
  endtask

  // --------------------------------------------------------------------------
  // Random names
  // --------------------------------------------------------------------------
  // Append one character; continuation top bits are sometimes scrambled.
  task automatic push_random_char();
    logic [20:0] cp;
    logic [7:0]  cont[3];
    int          kind;
    kind = $urandom_range(9);
    cp   = 21'($urandom);
    for (int i = 0; i < 3; i++) begin
      cont[i] = {2'b10, cp[6*(2-i) +: 6]};
      if ($urandom_range(7) == 0) cont[i][7:6] = 2'($urandom);
    end
    case (kind)
      0, 1, 2: name_bytes.push_back(8'($urandom_range(25)) + "a");
      3:       name_bytes.push_back(8'($urandom_range(25)) + "A");
      4:       name_bytes.push_back({1'b0, 7'($urandom)});
      5, 6: begin
        name_bytes.push_back({3'b110, cp[10:6]});
        name_bytes.push_back(cont[2]);
      end
      7, 8: begin
        name_bytes.push_back({4'b1110, cp[15:12]});
        name_bytes.push_back(cont[1]);
        name_bytes.push_back(cont[2]);
      end
      default: begin
        name_bytes.push_back({5'b11110, cp[20:18]});
        name_bytes.push_back(cont[0]);
        name_bytes.push_back(cont[1]);
        name_bytes.push_back(cont[2]);
      end
    endcase
  endtask

  // Build one name: mostly well-formed, sometimes xml-prefixed, digit-led,
  // cut short, or with a random byte dropped in.
  task automatic build_random_name();
    int flavor;
    int n_chars;
    name_bytes.delete();
    flavor  = $urandom_range(19);
    n_chars = $urandom_range(1, 5);
    if (flavor < 3) begin
      name_bytes.push_back($urandom_range(1) ? "x" : "X");
      name_bytes.push_back($urandom_range(1) ? "m" : "M");
      name_bytes.push_back($urandom_range(1) ? "l" : "L");
      n_chars = $urandom_range(2);
    end else if (flavor < 5) begin
      name_bytes.push_back(8'($urandom_range(9)) + "0");
    end
    for (int i = 0; i < n_chars; i++) push_random_char();
    if (flavor == 5 && name_bytes.size() > 1) begin
      void'(name_bytes.pop_back());
    end else if (flavor == 6) begin
      name_bytes.insert($urandom_range(name_bytes.size()), 8'($urandom));
    end
  endtask

  // Random names until the item budget is used
  task automatic test_random_names(input int budget, input bit noisy);
    int stop_at;
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      if (noisy && $urandom_range(29) == 0) begin
        send_byte_item(8'($urandom), 1'b0, 1'($urandom), 1'b1);
      end else begin
        build_random_name();
        send_name_bytes(1'($urandom), noisy);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst              <= 1'b1;
    bytes_ch.valid   <= 1'b0;
    bytes_ch.payload <= '0;
    gaps_on     = 1'b1;
    error_count = 0;
    items_sent  = 0;
    cycle_count = 0;
    clear_name_state();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_and_mode();
    test_bad_bytes();
    test_multibyte();
    // Let every verdict drain before the random part starts.
    wait_drained();

    test_random_names(RANDOM_ITEMS / 2, 1'b1);
    // Back-to-back stretch: no gaps on either side
    gaps_on = 1'b0;
    test_random_names(RANDOM_ITEMS / 4, 1'b0);
    gaps_on = 1'b1;
    test_random_names(RANDOM_ITEMS / 4, 1'b1);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
